// File: rtl/core/cal_pkg.sv
// Package for the cursor array list: sizes, operation codes, cell command.
// Used by cal_ctrl, cal_cell and cursor_array_list. No dependencies.
package cal_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 6;
  localparam int WORD_W   = 32;
  localparam int FUNC_W   = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_NONE       = 4'd0,
    FN_FIRST      = 4'd1,
    FN_LAST       = 4'd2,
    FN_SET_POS    = 4'd3,
    FN_PREV       = 4'd4,
    FN_NEXT       = 4'd5,
    FN_INS_BEFORE = 4'd6,
    FN_INS_AFTER  = 4'd7,
    FN_REMOVE     = 4'd8,
    FN_REPLACE    = 4'd9
  } func_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_WRITE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [IDX_W-1:0]         pos;
    logic signed [WORD_W-1:0] word;
  } cell_cmd_t;

endpackage

// File: rtl/core/cursor_array_list.sv
// Top level of the cursor array list: control, row of cells, result register.
// Depends on cal_pkg, cal_ctrl and cal_cell.
//
//   channel | handshake     | fields
//   --------+---------------+---------------------------------------------
//   command | start / busy  | func, target_position, data_word
//   result  | done (strobe) | cursor_position, current_value, entry_count,
//           |               | is_empty, is_full
//
// One item per cycle; busy stays low. Inserts and removes shift the cells
// from the operation position onward in parallel in the cycle the item is
// taken; the result is then registered from the updated cells through the
// cursor mux and driven on the ports together with done.
// Synchronous reset empties the list (cursor -1, count 0). Results cannot be
// stalled: done is high for exactly one cycle per item.
module cursor_array_list (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [cal_pkg::FUNC_W-1:0]         func,
  input  logic [4:0]                         target_position,
  input  logic signed [cal_pkg::WORD_W-1:0]  data_word,
  output logic                               done,
  output logic signed [5:0]                  cursor_position,
  output logic signed [cal_pkg::WORD_W-1:0]  current_value,
  output logic [cal_pkg::CNT_W-1:0]          entry_count,
  output logic                               is_empty,
  output logic                               is_full
);
  import cal_pkg::*;

  logic                     accept;
  logic                     pend;
  cell_cmd_t                cmd;
  logic [CNT_W-1:0]         cursor;
  logic [CNT_W-1:0]         count;
  logic signed [WORD_W-1:0] cell_word [CAPACITY];
  logic signed [WORD_W-1:0] read_word;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  cal_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .func            (func),
    .target_position (target_position),
    .data_word       (data_word),
    .cmd             (cmd),
    .cursor          (cursor),
    .count           (count)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_W-1:0] left_w;
    logic signed [WORD_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = cmd.word;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_word[i];
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end
    cal_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .slot       (IDX_W'(i)),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i])
    );
  end

  assign read_word = cell_word[cursor[IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      pend <= accept;
      done <= pend;
    end
  end

  always_ff @(posedge clk) begin
    cursor_position <= cursor;
    current_value   <= (count == '0) ? -32'sd1 : read_word;
    entry_count     <= count;
    is_empty        <= (count == '0);
    is_full         <= (count == CNT_W'(CAPACITY));
  end

endmodule

// File: rtl/core/cal_cell.sv
// One storage cell of the list: holds one entry, shifts with its neighbors.
// Depends on cal_pkg.
module cal_cell (
  input  logic                               clk,
  input  cal_pkg::cell_cmd_t                 cmd,
  input  logic [cal_pkg::IDX_W-1:0]          slot,
  input  logic signed [cal_pkg::WORD_W-1:0]  left_word,
  input  logic signed [cal_pkg::WORD_W-1:0]  right_word,
  output logic signed [cal_pkg::WORD_W-1:0]  word
);
  import cal_pkg::*;

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INSERT: begin
        if (slot > cmd.pos) begin
          word <= left_word;
        end else if (slot == cmd.pos) begin
          word <= cmd.word;
        end
      end
      CELL_REMOVE: begin
        if (slot >= cmd.pos) begin
          word <= right_word;
        end
      end
      CELL_WRITE: begin
        if (slot == cmd.pos) begin
          word <= cmd.word;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/core/cal_ctrl.sv
// Cursor and size control: decodes the operation, updates cursor and count,
// and broadcasts the shift/write command to the cells. Depends on cal_pkg.
module cal_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [cal_pkg::FUNC_W-1:0]         func,
  input  logic [cal_pkg::IDX_W-1:0]          target_position,
  input  logic signed [cal_pkg::WORD_W-1:0]  data_word,
  output cal_pkg::cell_cmd_t                 cmd,
  output logic [cal_pkg::CNT_W-1:0]          cursor,
  output logic [cal_pkg::CNT_W-1:0]          count
);
  import cal_pkg::*;

  logic [CNT_W-1:0] cursor_next;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] last;
  logic [CNT_W-1:0] ins_pos;
  logic             empty;
  logic             full;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(CAPACITY));
  assign last  = count - CNT_W'(1);

  always_comb begin
    cursor_next = cursor;
    count_next  = count;
    ins_pos     = '0;
    cmd.op      = CELL_HOLD;
    cmd.pos     = cursor[IDX_W-1:0];
    cmd.word    = data_word;
    if (accept) begin
      case (func)
        FN_FIRST: begin
          if (!empty) cursor_next = '0;
        end
        FN_LAST: begin
          cursor_next = last;
        end
        FN_SET_POS: begin
          if (!empty && ({1'b0, target_position} <= last)) begin
            cursor_next = {1'b0, target_position};
          end
        end
        FN_PREV: begin
          if (!empty && (cursor != '0)) cursor_next = cursor - CNT_W'(1);
        end
        FN_NEXT: begin
          if (!empty && (cursor != last)) cursor_next = cursor + CNT_W'(1);
        end
        FN_INS_BEFORE, FN_INS_AFTER: begin
          if (!full) begin
            if (empty) begin
              ins_pos = '0;
            end else if (func == FN_INS_AFTER) begin
              ins_pos = cursor + CNT_W'(1);
            end else begin
              ins_pos = cursor;
            end
            cursor_next = ins_pos;
            count_next  = count + CNT_W'(1);
            cmd.op      = CELL_INSERT;
            cmd.pos     = ins_pos[IDX_W-1:0];
          end
        end
        FN_REMOVE: begin
          if (!empty) begin
            cmd.op     = CELL_REMOVE;
            count_next = last;
            if (cursor == last) cursor_next = count - CNT_W'(2);
          end
        end
        FN_REPLACE: begin
          if (!empty) cmd.op = CELL_WRITE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '1;
      count  <= '0;
    end else begin
      cursor <= cursor_next;
      count  <= count_next;
    end
  end

endmodule
